// ----- sv/vfip_pkg.sv -----
`timescale 1ns / 1ps

package vfip_pkg;

  localparam int MAX_ELEMENTS_DEF = 6;
  localparam int MAX_PREFETCH_DEF = 8;

  localparam int ELEM_W     = 22;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 22;
  localparam int PD_W       = 5;

  localparam logic [CFG_IDX_W-1:0] REG_STREAM_SELECT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_0     = 4'd2;

  localparam logic [5:0] FMT_32       = 6'd6;
  localparam logic [5:0] FMT_32_32    = 6'd37;
  localparam logic [5:0] FMT_32_32_32_32 = 6'd38;
  localparam logic [5:0] FMT_32_32_32 = 6'd57;

  localparam logic [31:0] W0_PCOUNT_MASK = 32'h3800_0000;
  localparam logic [31:0] W1_FORMAT_MASK = 32'h003f_0000;
  localparam logic [31:0] W1_SIGN_MASK   = 32'h0000_1000;
  localparam logic [31:0] W1_NUMFMT_MASK = 32'h0000_2000;
  localparam logic [31:0] W1_MINI_MASK   = 32'h4000_0000;
  localparam logic [31:0] W1_SWIZ_MASK   = 32'h0000_0FFF;
  localparam logic [31:0] W2_OFFSET_MASK = 32'h7fff_ff00;
  localparam logic [31:0] W2_STRIDE_MASK = 32'h0000_00ff;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_UNKNOWN_FMT = 2'd1,
    ERR_UNALIGNED   = 2'd2,
    ERR_NO_USAGE    = 2'd3
  } err_t;

  typedef struct packed {
    logic [3:0] stream_select;
    logic [2:0] element_count;
  } cfg_t;

  typedef struct packed {
    logic        first_entry;
    logic [31:0] patch_entry;
    logic [31:0] old_word_zero;
    logic [31:0] old_word_one;
    logic [31:0] old_word_two;
  } item_t;

  typedef struct packed {
    logic [11:0] instruction_index;
    logic [31:0] new_word_zero;
    logic [31:0] new_word_one;
    logic [31:0] new_word_two;
    logic        was_patched;
    err_t        error_code;
  } result_t;

  function automatic logic [4:0] fmt_bytes(input logic [5:0] code);
    logic [4:0] b;
    unique case (code)
      FMT_32:          b = 5'd4;
      FMT_32_32:       b = 5'd8;
      FMT_32_32_32:    b = 5'd12;
      FMT_32_32_32_32: b = 5'd16;
      default:         b = 5'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/vfip_in_if.sv -----
`timescale 1ns / 1ps

interface vfip_in_if;
  logic        valid;
  logic        ready;
  logic        first_entry;
  logic [31:0] patch_entry;
  logic [31:0] old_word_zero;
  logic [31:0] old_word_one;
  logic [31:0] old_word_two;

  modport source (output valid, first_entry, patch_entry, old_word_zero, old_word_one,
                  old_word_two, input ready);
  modport sink   (input valid, first_entry, patch_entry, old_word_zero, old_word_one,
                  old_word_two, output ready);
endinterface

// ----- sv/vfip_out_if.sv -----
`timescale 1ns / 1ps

interface vfip_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] instruction_index;
  logic [31:0] new_word_zero;
  logic [31:0] new_word_one;
  logic [31:0] new_word_two;
  logic        was_patched;
  logic [1:0]  error_code;

  modport source (output valid, instruction_index, new_word_zero, new_word_one,
                  new_word_two, was_patched, error_code, input ready);
  modport sink   (input valid, instruction_index, new_word_zero, new_word_one,
                  new_word_two, was_patched, error_code, output ready);
endinterface

// ----- sv/vfip_cfg_if.sv -----
`timescale 1ns / 1ps

interface vfip_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vfip_pkg::CFG_IDX_W-1:0]  index;
  logic [vfip_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/vfip_cfg_regs.sv -----
`timescale 1ns / 1ps

module vfip_cfg_regs #(
  parameter int MAX_ELEMENTS = vfip_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  vfip_cfg_if.sink                                     cfg_chan,
  output vfip_pkg::cfg_t                               cfg,
  output logic [MAX_ELEMENTS-1:0][vfip_pkg::ELEM_W-1:0] elem_words
);

  vfip_pkg::cfg_t                               cfg_r;
  logic [MAX_ELEMENTS-1:0][vfip_pkg::ELEM_W-1:0] elem_r;
  logic                                         wr;

  assign cfg_chan.ready = 1'b1;
  assign wr             = cfg_chan.valid && cfg_chan.ready;
  assign cfg            = cfg_r;
  assign elem_words     = elem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= '0;
      elem_r <= '0;
    end else if (wr) begin
      if (cfg_chan.index == vfip_pkg::REG_STREAM_SELECT) begin
        cfg_r.stream_select <= cfg_chan.data[3:0];
      end
      if (cfg_chan.index == vfip_pkg::REG_ELEMENT_COUNT) begin
        cfg_r.element_count <= cfg_chan.data[2:0];
      end
      for (int e = 0; e < MAX_ELEMENTS; e++) begin
        if (cfg_chan.index == vfip_pkg::REG_ELEMENT_0 + vfip_pkg::CFG_IDX_W'(e)) begin
          elem_r[e] <= cfg_chan.data[vfip_pkg::ELEM_W-1:0];
        end
      end
    end
  end

endmodule

// ----- sv/vfip_patch_core.sv -----
`timescale 1ns / 1ps

module vfip_patch_core #(
  parameter int MAX_ELEMENTS = vfip_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_PREFETCH = vfip_pkg::MAX_PREFETCH_DEF
) (
  input  vfip_pkg::cfg_t                               cfg,
  input  logic [MAX_ELEMENTS-1:0][vfip_pkg::ELEM_W-1:0] elem_words,
  input  vfip_pkg::item_t                              item,
  input  logic [vfip_pkg::PD_W-1:0]                    pd,
  output vfip_pkg::result_t                            res,
  output logic [vfip_pkg::PD_W-1:0]                    pd_nxt
);

  logic [2:0]                  count;
  logic [3:0]                  usage;
  logic [3:0]                  stream;
  logic [6:0]                  total;
  logic [6:0]                  off;
  logic                        unknown;
  logic                        found;
  logic [vfip_pkg::ELEM_W-1:0] sel_word;
  logic [vfip_pkg::PD_W-1:0]   pd_eff;

  assign count  = (cfg.element_count > 3'(MAX_ELEMENTS)) ? 3'(MAX_ELEMENTS)
                                                         : cfg.element_count;
  assign usage  = item.patch_entry[15:12];
  assign stream = item.patch_entry[19:16];
  assign pd_eff = item.first_entry ? '0 : pd;

  always_comb begin
    logic [4:0] b;
    total    = '0;
    off      = '0;
    unknown  = 1'b0;
    found    = 1'b0;
    sel_word = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      b = vfip_pkg::fmt_bytes(elem_words[i][17:12]);
      if (3'(i) < count) begin
        if (b == 5'd0) begin
          unknown = 1'b1;
        end
        total = total + 7'(b);
        if (!found && elem_words[i][21:18] == usage) begin
          found    = 1'b1;
          sel_word = elem_words[i];
        end else if (!found) begin
          off = off + 7'(b);
        end
      end
    end
  end

  logic [5:0] code;
  logic [4:0] stride;
  logic [4:0] offdw;
  logic [2:0] size_dw;
  logic [4:0] diff;
  logic [3:0] fetch_dw;
  logic [2:0] pcount;
  logic       mini;
  logic       numfmt;
  logic       hit;
  vfip_pkg::err_t err;

  assign code    = sel_word[17:12];
  assign stride  = total[6:2];
  assign offdw   = off[6:2];
  assign size_dw = 3'((7'(vfip_pkg::fmt_bytes(code)) + 7'd3) >> 2);
  assign numfmt  = (code != vfip_pkg::FMT_32);
  assign diff    = stride - pd_eff;

  always_comb begin
    fetch_dw = '0;
    if ((6'(pd_eff) <= 6'(offdw) + 6'(size_dw)) && (pd_eff < stride)) begin
      fetch_dw = (diff > 5'(MAX_PREFETCH)) ? 4'(MAX_PREFETCH) : diff[3:0];
    end
  end

  assign mini   = (fetch_dw == 4'd0);
  assign pcount = mini ? 3'd0 : 3'(fetch_dw - 4'd1);

  always_comb begin
    priority if (unknown) begin
      err = vfip_pkg::ERR_UNKNOWN_FMT;
    end else if (total[1:0] != 2'd0) begin
      err = vfip_pkg::ERR_UNALIGNED;
    end else if (stream == cfg.stream_select && !found) begin
      err = vfip_pkg::ERR_NO_USAGE;
    end else begin
      err = vfip_pkg::ERR_OK;
    end
  end

  assign hit = (err == vfip_pkg::ERR_OK) && (stream == cfg.stream_select) && found;

  always_comb begin
    res.instruction_index = item.patch_entry[11:0];
    res.was_patched       = hit;
    res.error_code        = err;
    res.new_word_zero     = item.old_word_zero;
    res.new_word_one      = item.old_word_one;
    res.new_word_two      = item.old_word_two;
    pd_nxt                = pd_eff;
    if (hit) begin
      res.new_word_zero = (item.old_word_zero & ~vfip_pkg::W0_PCOUNT_MASK)
                        | {2'b00, pcount, 27'd0};
      res.new_word_one  = (item.old_word_one & ~(vfip_pkg::W1_FORMAT_MASK
                                               | vfip_pkg::W1_SIGN_MASK
                                               | vfip_pkg::W1_NUMFMT_MASK
                                               | vfip_pkg::W1_MINI_MASK
                                               | vfip_pkg::W1_SWIZ_MASK))
                        | {1'b0, mini, 8'd0, code, 2'b00, numfmt, 1'b0, sel_word[11:0]};
      res.new_word_two  = (item.old_word_two & ~(vfip_pkg::W2_OFFSET_MASK
                                               | vfip_pkg::W2_STRIDE_MASK))
                        | {1'b0, 18'd0, offdw, 3'd0, stride};
      pd_nxt            = pd_eff + 5'(fetch_dw);
    end
  end

endmodule

// ----- sv/vertex_fetch_instruction_patcher.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Transfer carries
// in_chan   sink       first_entry, patch_entry, old_word_zero/one/two
// out_chan  source     instruction_index, new_word_zero/one/two, was_patched, error_code
// cfg_chan  sink       index, data (register write)
//
// One transfer in and one out per cycle while out_chan is not stalled; each item passes
// through the input register and then the result register. The prefetched dword count is
// updated as an item moves from the input register to the result register, so consecutive
// items chain with no gap. Reset (rst_n low, synchronous) empties both registers and clears
// configuration. A stalled result holds its register; the input register still fills behind it.

module vertex_fetch_instruction_patcher #(
  parameter int MAX_ELEMENTS = vfip_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_PREFETCH = vfip_pkg::MAX_PREFETCH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  vfip_in_if.sink       in_chan,
  vfip_out_if.source    out_chan,
  vfip_cfg_if.sink      cfg_chan
);

  vfip_pkg::cfg_t                               cfg;
  logic [MAX_ELEMENTS-1:0][vfip_pkg::ELEM_W-1:0] elem_words;

  logic                      in_valid_r;
  vfip_pkg::item_t           item_r;
  logic                      out_valid_r;
  vfip_pkg::result_t         res_r;
  vfip_pkg::result_t         res_nxt;
  logic [vfip_pkg::PD_W-1:0] pd_r;
  logic [vfip_pkg::PD_W-1:0] pd_nxt;
  logic                      advance;
  logic                      take;

  vfip_cfg_regs #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_chan   (cfg_chan),
    .cfg        (cfg),
    .elem_words (elem_words)
  );

  vfip_patch_core #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_PREFETCH (MAX_PREFETCH)
  ) u_core (
    .cfg        (cfg),
    .elem_words (elem_words),
    .item       (item_r),
    .pd         (pd_r),
    .res        (res_nxt),
    .pd_nxt     (pd_nxt)
  );

  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pd_r        <= '0;
    end else begin
      if (take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pd_r        <= pd_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.first_entry   <= in_chan.first_entry;
      item_r.patch_entry   <= in_chan.patch_entry;
      item_r.old_word_zero <= in_chan.old_word_zero;
      item_r.old_word_one  <= in_chan.old_word_one;
      item_r.old_word_two  <= in_chan.old_word_two;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.instruction_index = res_r.instruction_index;
  assign out_chan.new_word_zero     = res_r.new_word_zero;
  assign out_chan.new_word_one      = res_r.new_word_one;
  assign out_chan.new_word_two      = res_r.new_word_two;
  assign out_chan.was_patched       = res_r.was_patched;
  assign out_chan.error_code        = res_r.error_code;

endmodule

// ----- sv/vfip_checker.sv -----
`timescale 1ns / 1ps

module vfip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word_one,
  input logic        out_was_patched,
  input logic [1:0]  out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word_one))
    else $error("stalled result changed");

  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an input transfer two cycles earlier");

  a_patch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_patched |-> out_error_code == vfip_pkg::ERR_OK)
    else $error("patched result carries an error code");

endmodule

bind vertex_fetch_instruction_patcher vfip_checker u_vfip_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_word_one    (out_chan.new_word_one),
  .out_was_patched (out_chan.was_patched),
  .out_error_code  (out_chan.error_code)
);

// ----- sim/tb_vertex_fetch_instruction_patcher.sv -----
`timescale 1ns / 1ps

module tb_vertex_fetch_instruction_patcher;

  localparam int MAX_ELEMS    = vfip_pkg::MAX_ELEMENTS_DEF;
  localparam int MAX_FETCH    = vfip_pkg::MAX_PREFETCH_DEF;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int LONG_HOLD    = 80;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 10;

  localparam int LAY_RESET  = 0;
  localparam int LAY_BADFMT = 1;
  localparam int LAY_FULL   = 2;
  localparam int LAY_OVER   = 3;
  localparam int LAY_ONE    = 4;

  typedef struct {
    int              layout;
    vfip_pkg::item_t it;
    bit              typed;
    vfip_pkg::err_t  terr;
  } dir_row_t;

  logic clk;
  logic rst_n;

  vfip_in_if  in_chan ();
  vfip_out_if out_chan ();
  vfip_cfg_if cfg_chan ();

  vertex_fetch_instruction_patcher DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  logic [3:0]  lay_stream;
  logic [2:0]  lay_count;
  logic [21:0] lay_elem [6];
  logic [4:0]  fetched_dwords;

  logic [5:0] known_codes [4];

  vfip_pkg::result_t pending_results [$];
  int                items_sent;
  int                results_seen;
  int                mismatches;
  int                quiet;
  bit                hold_pending;
  int                in_calm = 0;

  logic              row_typed;
  vfip_pkg::err_t    row_err;
  vfip_pkg::item_t   accepted_item;
  vfip_pkg::result_t predicted;
  vfip_pkg::result_t wanted;

  dir_row_t directed_rows [$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int elem_bytes(input logic [5:0] code);
    case (code)
      vfip_pkg::FMT_32:          return 4;
      vfip_pkg::FMT_32_32:       return 8;
      vfip_pkg::FMT_32_32_32:    return 12;
      vfip_pkg::FMT_32_32_32_32: return 16;
      default:                   return 0;
    endcase
  endfunction

  function automatic vfip_pkg::result_t patch_predict(input vfip_pkg::item_t it);
    vfip_pkg::result_t r;
    logic [3:0] usage;
    logic [3:0] strm;
    logic [5:0] code;
    logic [2:0] pcount;
    logic       mini;
    int         i, cnt, total, off, hit, sz, stride, offdw, size_dw, fetch_dw;
    r.instruction_index = it.patch_entry[11:0];
    r.new_word_zero     = it.old_word_zero;
    r.new_word_one      = it.old_word_one;
    r.new_word_two      = it.old_word_two;
    r.was_patched       = 1'b0;
    r.error_code        = vfip_pkg::ERR_OK;
    usage = it.patch_entry[15:12];
    strm  = it.patch_entry[19:16];
    cnt   = (lay_count > MAX_ELEMS) ? MAX_ELEMS : lay_count;
    if (it.first_entry) fetched_dwords = '0;
    total = 0;
    for (i = 0; i < cnt; i++) begin
      sz = elem_bytes(lay_elem[i][17:12]);
      if (sz == 0) r.error_code = vfip_pkg::ERR_UNKNOWN_FMT;
      total += sz;
    end
    if (r.error_code == vfip_pkg::ERR_OK && (total % 4) != 0)
      r.error_code = vfip_pkg::ERR_UNALIGNED;
    if (r.error_code == vfip_pkg::ERR_OK && strm == lay_stream) begin
      hit = -1;
      off = 0;
      for (i = 0; i < cnt && hit < 0; i++) begin
        if (lay_elem[i][21:18] == usage) hit = i;
        else off += elem_bytes(lay_elem[i][17:12]);
      end
      if (hit < 0) begin
        r.error_code = vfip_pkg::ERR_NO_USAGE;
      end else begin
        code     = lay_elem[hit][17:12];
        size_dw  = (elem_bytes(code) + 3) / 4;
        stride   = total / 4;
        offdw    = off / 4;
        fetch_dw = 0;
        if (fetched_dwords <= offdw + size_dw && fetched_dwords < stride)
          fetch_dw = stride - fetched_dwords;
        if (fetch_dw > MAX_FETCH) fetch_dw = MAX_FETCH;
        mini   = (fetch_dw == 0);
        pcount = mini ? 3'd0 : 3'(fetch_dw - 1);
        fetched_dwords = 5'(fetched_dwords + fetch_dw);
        r.new_word_zero[29:27] = pcount;
        r.new_word_one[11:0]   = lay_elem[hit][11:0];
        r.new_word_one[12]     = 1'b0;
        r.new_word_one[13]     = (code != vfip_pkg::FMT_32);
        r.new_word_one[21:16]  = code;
        r.new_word_one[30]     = mini;
        r.new_word_two[7:0]    = 8'(stride);
        r.new_word_two[30:8]   = 23'(offdw);
        r.was_patched          = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int next_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic dir_row_t mk_row(input int layout, input logic first,
                                      input logic [31:0] entry, input logic [31:0] w0,
                                      input logic [31:0] w1, input logic [31:0] w2,
                                      input bit typed, input vfip_pkg::err_t terr);
    dir_row_t row;
    row.layout = layout;
    row.it     = '{first, entry, w0, w1, w2};
    row.typed  = typed;
    row.terr   = terr;
    return row;
  endfunction

  task automatic write_reg(input logic [vfip_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vfip_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    case (idx)
      vfip_pkg::REG_STREAM_SELECT: lay_stream = value[3:0];
      vfip_pkg::REG_ELEMENT_COUNT: lay_count  = value[2:0];
      default: lay_elem[int'(idx - vfip_pkg::REG_ELEMENT_0)] = value;
    endcase
  endtask

  task automatic set_layout(input logic [3:0] s, input logic [2:0] c,
                            input logic [21:0] e [6]);
    int k;
    write_reg(vfip_pkg::REG_STREAM_SELECT, 22'(s));
    write_reg(vfip_pkg::REG_ELEMENT_COUNT, 22'(c));
    for (k = 0; k < 6; k++)
      write_reg(vfip_pkg::CFG_IDX_W'(vfip_pkg::REG_ELEMENT_0 + k), e[k]);
  endtask

  task automatic load_directed_layout(input int which);
    logic [21:0] e [6];
    case (which)
      LAY_BADFMT: begin
        e = '{{4'd1, vfip_pkg::FMT_32, 12'hFFF}, {4'd2, 6'd0, 12'h000},
              {4'd3, vfip_pkg::FMT_32_32_32_32, 12'h5A5}, 22'd0, 22'd0, 22'd0};
        set_layout(4'd0, 3'd3, e);
      end
      LAY_FULL: begin
        e = '{{4'd0, vfip_pkg::FMT_32_32_32_32, 12'h000},
              {4'hF, vfip_pkg::FMT_32_32_32, 12'hFFF},
              {4'd4, vfip_pkg::FMT_32_32, 12'h123}, {4'd4, vfip_pkg::FMT_32, 12'h456},
              {4'd9, vfip_pkg::FMT_32_32_32_32, 12'h789},
              {4'd2, vfip_pkg::FMT_32_32_32, 12'hABC}};
        set_layout(4'hF, 3'd6, e);
      end
      LAY_OVER: begin
        e = '{{4'd0, vfip_pkg::FMT_32_32, 12'h111}, {4'd1, vfip_pkg::FMT_32_32, 12'h222},
              {4'd2, vfip_pkg::FMT_32_32, 12'h333}, {4'd3, vfip_pkg::FMT_32_32, 12'h444},
              {4'd4, vfip_pkg::FMT_32_32, 12'h555}, {4'd8, vfip_pkg::FMT_32_32, 12'h666}};
        set_layout(4'd5, 3'd7, e);
      end
      LAY_ONE: begin
        e = '{{4'd7, vfip_pkg::FMT_32, 12'hABC}, {4'd3, 6'h3F, 12'h000}, 22'h3FFFFF,
              22'd0, 22'd0, 22'd0};
        set_layout(4'd0, 3'd1, e);
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic send_item(input vfip_pkg::item_t it, input bit typed,
                           input vfip_pkg::err_t terr);
    int gap;
    gap = next_gap(in_calm);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.first_entry   <= it.first_entry;
    in_chan.patch_entry   <= it.patch_entry;
    in_chan.old_word_zero <= it.old_word_zero;
    in_chan.old_word_one  <= it.old_word_one;
    in_chan.old_word_two  <= it.old_word_two;
    row_typed             <= typed;
    row_err               <= terr;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  always @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      accepted_item = '{in_chan.first_entry, in_chan.patch_entry, in_chan.old_word_zero,
                        in_chan.old_word_one, in_chan.old_word_two};
      predicted = patch_predict(accepted_item);
      if (row_typed)
        predicted = '{accepted_item.patch_entry[11:0], accepted_item.old_word_zero,
                      accepted_item.old_word_one, accepted_item.old_word_two, 1'b0, row_err};
      pending_results.push_back(predicted);
    end
  end

  always @(posedge clk) begin
    if (out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, index %h", $time, out_chan.instruction_index);
        mismatches++;
      end else begin
        wanted = pending_results.pop_front();
        check_field("instruction_index", 32'(wanted.instruction_index),
                    32'(out_chan.instruction_index));
        check_field("new_word_zero", wanted.new_word_zero, out_chan.new_word_zero);
        check_field("new_word_one", wanted.new_word_one, out_chan.new_word_one);
        check_field("new_word_two", wanted.new_word_two, out_chan.new_word_two);
        check_field("was_patched", 32'(wanted.was_patched), 32'(out_chan.was_patched));
        check_field("error_code", 32'(wanted.error_code), 32'(out_chan.error_code));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int gap;
    int calm;
    calm = 0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = next_gap(calm);
      if (hold_pending) begin
        gap = LONG_HOLD;
        hold_pending = 1'b0;
      end
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  initial begin
    vfip_pkg::item_t it;
    int          p, n, k, used, cur_lay;
    logic [3:0]  s;
    logic [2:0]  c;
    logic [5:0]  code;
    logic [3:0]  u;
    logic [21:0] rnd_elem [6];

    known_codes = '{vfip_pkg::FMT_32, vfip_pkg::FMT_32_32, vfip_pkg::FMT_32_32_32,
                    vfip_pkg::FMT_32_32_32_32};
    lay_stream     = '0;
    lay_count      = '0;
    lay_elem       = '{default: '0};
    fetched_dwords = '0;
    items_sent     = 0;
    results_seen   = 0;
    mismatches     = 0;
    quiet          = 0;
    hold_pending   = 1'b0;

    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.first_entry   <= 1'b0;
    in_chan.patch_entry   <= '0;
    in_chan.old_word_zero <= '0;
    in_chan.old_word_one  <= '0;
    in_chan.old_word_two  <= '0;
    cfg_chan.valid        <= 1'b0;
    cfg_chan.index        <= '0;
    cfg_chan.data         <= '0;
    row_typed             <= 1'b0;
    row_err               <= vfip_pkg::ERR_OK;

    directed_rows.push_back(mk_row(LAY_RESET, 1'b0, 32'h0000_0000, 32'h0, 32'h0, 32'h0,
                                   1'b1, vfip_pkg::ERR_NO_USAGE));
    directed_rows.push_back(mk_row(LAY_RESET, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_RESET, 1'b0, 32'h0000_5ABC, 32'hA5A5_A5A5,
                                   32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1,
                                   vfip_pkg::ERR_NO_USAGE));
    directed_rows.push_back(mk_row(LAY_BADFMT, 1'b0, 32'h0001_1001, 32'h1111_1111,
                                   32'h2222_2222, 32'h3333_3333, 1'b1,
                                   vfip_pkg::ERR_UNKNOWN_FMT));
    directed_rows.push_back(mk_row(LAY_BADFMT, 1'b1, 32'h0000_1FFF, 32'hFFFF_FFFF,
                                   32'h0, 32'hFFFF_FFFF, 1'b1, vfip_pkg::ERR_UNKNOWN_FMT));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b1, 32'h000F_0000, 32'h0, 32'h0, 32'h0,
                                   1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b0, 32'h000F_F001, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b0, 32'h000F_4002, 32'h1234_5678,
                                   32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b0, 32'h000F_9003, 32'hF0F0_F0F0,
                                   32'h8765_4321, 32'hFFFF_0000, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b0, 32'h000F_2004, 32'h0, 32'hFFFF_FFFF,
                                   32'h0, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b0, 32'h000F_2005, 32'hFFFF_FFFF, 32'h0,
                                   32'hFFFF_FFFF, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b0, 32'h000F_6006, 32'hDEAD_BEEF,
                                   32'hCAFE_F00D, 32'h0BAD_F00D, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b0, 32'h000E_0007, 32'h1357_9BDF,
                                   32'h2468_ACE0, 32'hFEDC_BA98, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_FULL, 1'b0, 32'hFFF0_0000, 32'h0, 32'h0, 32'h0,
                                   1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_OVER, 1'b1, 32'h0005_8123, 32'h7FFF_FFFF,
                                   32'hBFFF_FFFF, 32'h8000_0000, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_OVER, 1'b0, 32'h0005_7000, 32'h0, 32'h0, 32'h0,
                                   1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_ONE, 1'b1, 32'h0000_7FFE, 32'h0, 32'hFFFF_FFFF,
                                   32'h0, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_ONE, 1'b0, 32'h0000_7FFD, 32'hFFFF_FFFF, 32'h0,
                                   32'hFFFF_FFFF, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_ONE, 1'b1, 32'h0000_7010, 32'h5555_5555,
                                   32'hAAAA_AAAA, 32'h5555_5555, 1'b0, vfip_pkg::ERR_OK));
    directed_rows.push_back(mk_row(LAY_ONE, 1'b0, 32'h0000_3011, 32'hAAAA_AAAA,
                                   32'h5555_5555, 32'hAAAA_AAAA, 1'b0, vfip_pkg::ERR_OK));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_lay = LAY_RESET;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].layout != cur_lay) begin
        in_chan.valid <= 1'b0;
        wait_drained();
        cur_lay = directed_rows[r].layout;
        load_directed_layout(cur_lay);
      end
      send_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].terr);
    end

    for (p = 0; p < PHASES; p++) begin
      in_chan.valid <= 1'b0;
      wait_drained();
      s = (p == 0) ? 4'hF : (p == 1) ? 4'h0 : 4'($urandom_range(0, 15));
      c = (p == 0) ? 3'd6 : (p == 1) ? 3'd7 : (p == 2) ? 3'd0 : 3'($urandom_range(1, 7));
      for (k = 0; k < 6; k++) begin
        if (p >= 3 && $urandom_range(0, 9) == 0) code = 6'($urandom);
        else code = known_codes[$urandom_range(0, 3)];
        u = (p % 2 == 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        rnd_elem[k] = {u, code, 12'($urandom)};
      end
      set_layout(s, c, rnd_elem);
      used = (lay_count > MAX_ELEMS) ? MAX_ELEMS : lay_count;
      if (p == 4) hold_pending = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        it.first_entry   = ($urandom_range(0, 5) == 0);
        it.patch_entry   = $urandom;
        it.old_word_zero = $urandom;
        it.old_word_one  = $urandom;
        it.old_word_two  = $urandom;
        if ($urandom_range(0, 4) != 0) it.patch_entry[19:16] = lay_stream;
        if (used != 0 && $urandom_range(0, 3) != 0)
          it.patch_entry[15:12] = lay_elem[$urandom_range(0, used - 1)][21:18];
        send_item(it, 1'b0, vfip_pkg::ERR_OK);
      end
    end

    in_chan.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
